/* hdl/sbsm_pkg.sv */
// package for the serial bank switch mapper
// transaction payload types, access and target codes, bank register set
// no dependencies
package sbsm_pkg;

  // access kinds carried in the opcode field
  typedef enum logic [1:0] {
    OP_CPU_WR = 2'd0,
    OP_CPU_RD = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // memory selected by a result
  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_CHR_ROM = 3'd2,
    TGT_PRG_RAM = 3'd3,
    TGT_CHR_RAM = 3'd4
  } tgt_e;

  // loader destination, address bits 14..13
  typedef enum logic [1:0] {
    REG_CONTROL  = 2'd0,
    REG_CHR_LOW  = 2'd1,
    REG_CHR_HIGH = 2'd2,
    REG_PRG      = 2'd3
  } reg_sel_e;

  // configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_IS_RAM     = 1'b1;

  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [4:0] CTRL_RESET      = 5'h0C;
  localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
  localparam logic [4:0] PRG_COUNT_MAX   = 5'd16;
  localparam logic [2:0] LOADER_BITS     = 3'd5;
  localparam logic [2:0] LOADER_LAST     = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [17:0] offset;
    logic [1:0]  mirroring;
  } out_item_t;

  // bank registers written by the serial loader
  typedef struct packed {
    logic [4:0] ctrl;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] prg;
  } bank_regs_t;

  typedef struct packed {
    logic [4:0] prg_bank_count;
    logic       chr_is_ram;
  } cfg_t;

endpackage

/* hdl/sbsm_loader.sv */
// five-bit serial loader and the bank registers it commits to
// depends on sbsm_pkg
module sbsm_loader import sbsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  in_item_t   item_i,
  output bank_regs_t regs_o,
  output logic [1:0] mirror_o
);

  bank_regs_t regs_q, regs_d;
  logic [4:0] sval_q, sval_d;
  logic [2:0] scnt_q, scnt_d;
  logic [2:0] cnt;
  logic [2:0] cnt_new;
  logic [4:0] val_new;
  logic       reg_wr;

  always_comb begin
    regs_d  = regs_q;
    sval_d  = sval_q;
    scnt_d  = scnt_q;
    cnt     = (scnt_q > LOADER_LAST) ? 3'd0 : scnt_q;
    val_new = sval_q | (5'(item_i.write_data[0]) << cnt);
    cnt_new = cnt + 3'd1;
    reg_wr  = fire_i && (item_i.opcode == OP_CPU_WR) && item_i.address[15];
    if (reg_wr) begin
      if (item_i.write_data[7]) begin
        // loader reset, forces the fixed-last prg mode
        sval_d      = '0;
        scnt_d      = '0;
        regs_d.ctrl = regs_q.ctrl | CTRL_RESET;
      end else if (cnt_new == LOADER_BITS) begin
        sval_d = '0;
        scnt_d = '0;
        unique case (reg_sel_e'(item_i.address[14:13]))
          REG_CONTROL:  regs_d.ctrl     = val_new;
          REG_CHR_LOW:  regs_d.chr_low  = val_new;
          REG_CHR_HIGH: regs_d.chr_high = val_new;
          REG_PRG:      regs_d.prg      = val_new;
          default:      regs_d.prg      = val_new;
        endcase
      end else begin
        sval_d = val_new;
        scnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{ctrl: CTRL_RESET, chr_low: '0, chr_high: '0, prg: '0};
      sval_q <= '0;
      scnt_q <= '0;
    end else begin
      regs_q <= regs_d;
      sval_q <= sval_d;
      scnt_q <= scnt_d;
    end
  end

  assign regs_o   = regs_q;
  assign mirror_o = regs_d.ctrl[1:0];

endmodule

/* hdl/sbsm_xlate.sv */
// address translation from bus address to target memory and byte offset
// depends on sbsm_pkg
module sbsm_xlate import sbsm_pkg::*; (
  input  in_item_t   item_i,
  input  bank_regs_t regs_i,
  input  cfg_t       cfg_i,
  input  logic [1:0] mirror_i,
  output out_item_t  res_o
);

  logic [3:0] prg_sel;
  logic [3:0] prg_last;
  logic [3:0] prg_bank;
  logic [4:0] chr_bank;
  logic       prg_half;
  logic       chr_half;
  logic       cpu_acc;
  logic       wram_hit;

  always_comb begin
    prg_sel  = regs_i.prg[3:0];
    prg_half = item_i.address[14];
    chr_half = item_i.address[12];
    // clamp bank count into 1..16, take the last bank
    if (cfg_i.prg_bank_count == 5'd0) begin
      prg_last = 4'd0;
    end else if (cfg_i.prg_bank_count > PRG_COUNT_MAX) begin
      prg_last = 4'd15;
    end else begin
      prg_last = 4'(cfg_i.prg_bank_count - 5'd1);
    end
    case (regs_i.ctrl[3:2])
      2'd2:    prg_bank = prg_half ? prg_sel : 4'd0;
      2'd3:    prg_bank = prg_half ? prg_last : prg_sel;
      default: prg_bank = {prg_sel[3:1], prg_half};
    endcase
    if (!regs_i.ctrl[4]) begin
      chr_bank = {regs_i.chr_low[4:1], chr_half};
    end else begin
      chr_bank = chr_half ? regs_i.chr_high : regs_i.chr_low;
    end
  end

  always_comb begin
    cpu_acc  = (item_i.opcode == OP_CPU_WR) || (item_i.opcode == OP_CPU_RD);
    wram_hit = item_i.address[15:13] == 3'b011;
    res_o.target    = TGT_NONE;
    res_o.offset    = '0;
    res_o.mirroring = mirror_i;
    if (cpu_acc && wram_hit) begin
      res_o.target = TGT_PRG_RAM;
      res_o.offset = {5'd0, item_i.address[12:0]};
    end else if ((item_i.opcode == OP_CPU_RD) && item_i.address[15]) begin
      res_o.target = TGT_PRG_ROM;
      res_o.offset = {prg_bank, item_i.address[13:0]};
    end else if (item_i.opcode == OP_PPU_RD) begin
      if (cfg_i.chr_is_ram) begin
        res_o.target = TGT_CHR_RAM;
        res_o.offset = {5'd0, item_i.address[12:0]};
      end else begin
        res_o.target = TGT_CHR_ROM;
        res_o.offset = {1'b0, chr_bank, item_i.address[11:0]};
      end
    end
  end

endmodule

/* hdl/serial_bank_switch_mapper.sv */
// top level of the serial bank switch mapper: input register, loader, translation, result register
// depends on sbsm_pkg, sbsm_loader, sbsm_xlate
//
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  in_data_i   (opcode, address, write_data)
// out       output     out_valid_o/out_stall_i out_data_o (target, offset, mirroring)
// cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; each result passes
// through the input register, one translation pass and then the result register
// bank registers update when an item moves from the input register into the result register
// reset clears handshake state and loader, sets bank registers and configuration to reset values
// a stalled result holds; the input register keeps accepting while the result can drain
module serial_bank_switch_mapper import sbsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // input register
  logic       a_valid_q, a_valid_d;
  in_item_t   a_item_q;
  // result register
  logic       r_valid_q, r_valid_d;
  out_item_t  r_item_q;
  out_item_t  res;
  // configuration
  cfg_t       cfg_q;
  bank_regs_t regs;
  logic [1:0] mirror;
  logic       r_ready;
  logic       a_fire;
  logic       in_fire;

  // result register frees up when empty or being taken this cycle
  assign r_ready    = !r_valid_q || !out_stall_i;
  assign a_fire     = a_valid_q && r_ready;
  assign in_stall_o = a_valid_q && !r_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_fire) begin
      a_valid_d = 1'b1;
    end else if (a_fire) begin
      a_valid_d = 1'b0;
    end
    r_valid_d = r_valid_q;
    if (a_fire) begin
      r_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      r_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      r_valid_q <= r_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= in_data_i;
    end
    if (a_fire) begin
      r_item_q <= res;
    end
  end

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prg_bank_count: PRG_COUNT_RESET, chr_is_ram: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRG_BANK_COUNT: cfg_q.prg_bank_count <= cfg_data_i;
        CFG_CHR_IS_RAM:     cfg_q.chr_is_ram     <= cfg_data_i[0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  // serial loader sees each item leaving the input register; only register writes advance it
  sbsm_loader u_loader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (a_fire),
    .item_i   (a_item_q),
    .regs_o   (regs),
    .mirror_o (mirror)
  );

  // translation uses bank registers as they stand before this item,
  // mirroring as it stands after it
  sbsm_xlate u_xlate (
    .item_i   (a_item_q),
    .regs_i   (regs),
    .cfg_i    (cfg_q),
    .mirror_i (mirror),
    .res_o    (res)
  );

  assign out_valid_o = r_valid_q;
  assign out_data_o  = r_item_q;

  // an item leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni) a_fire |=> r_valid_q)
    else $error("result register missed a transaction");

  // back-pressure on the input only while an item is held
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> a_valid_q)
    else $error("input stalled with empty input register");

  // character ram results only when configured for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && (r_item_q.target == TGT_CHR_RAM)) |-> cfg_q.chr_is_ram)
    else $error("chr ram target without chr ram configured");

  // register writes and unmapped accesses carry no offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && (r_item_q.target == TGT_NONE)) |-> (r_item_q.offset == '0))
    else $error("non-zero offset on empty target");

endmodule

/* test/tb.sv */
// self-checking testbench for serial_bank_switch_mapper
// drives random and directed bus accesses through the valid/stall channels, predicts each result
// depends on sbsm_pkg and the serial_bank_switch_mapper rtl
`timescale 1ns / 100ps

module tb;
  import sbsm_pkg::*;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_idx_i   = CFG_PRG_BANK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  serial_bank_switch_mapper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // accesses waiting to be sent, and translations waiting to come back
  in_item_t  pending_accesses[$];
  out_item_t expected_results[$];
  int        error_count = 0;

  // predicted mapper state
  logic [4:0] ldr_value;
  logic [2:0] ldr_count;
  bank_regs_t banks;
  // configuration copy, follows every configuration write
  logic [4:0] bank_count_cfg = PRG_COUNT_RESET;
  logic       chr_ram_cfg    = 1'b0;

  // sender burst / gap bookkeeping
  int burst_left;
  int gap_left;
  // receiver stall pattern
  int stall_mode;
  int mode_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // base of a 16k program window, half selects the 0xC000 window
  function automatic logic [17:0] prg_window(logic half);
    int unsigned bank;
    int unsigned count;
    bank  = banks.prg & 5'h0F;
    count = bank_count_cfg;
    case (banks.ctrl[3:2])
      2'd2: begin
        return half ? 18'(bank * 'h4000) : 18'd0;
      end
      2'd3: begin
        // out of range bank counts are clamped for the fixed last bank
        if (count < 1) count = 1;
        if (count > PRG_COUNT_MAX) count = PRG_COUNT_MAX;
        return half ? 18'((count - 1) * 'h4000) : 18'(bank * 'h4000);
      end
      default: begin
        return 18'(((bank & 'h0E) + half) * 'h4000);
      end
    endcase
  endfunction

  // base of a 4k character window, half selects the 0x1000 window
  function automatic logic [17:0] chr_window(logic half);
    if (!banks.ctrl[4]) return 18'(((banks.chr_low & 5'h1E) + half) * 'h1000);
    return half ? 18'(banks.chr_high * 'h1000) : 18'(banks.chr_low * 'h1000);
  endfunction

  // expected translation of one access, advancing the loader and bank registers
  function automatic out_item_t translate_access(in_item_t acc);
    out_item_t res;
    op_e       op;
    op = op_e'(acc.opcode);
    res.target = TGT_NONE;
    res.offset = '0;
    if (op == OP_CPU_WR || op == OP_CPU_RD) begin
      if (acc.address >= 16'h6000 && acc.address <= 16'h7FFF) begin
        // work ram, read or write
        res.target = TGT_PRG_RAM;
        res.offset = 18'(acc.address[12:0]);
      end else if (acc.address[15]) begin
        if (op == OP_CPU_WR) begin
          if (acc.write_data[7]) begin
            // loader clear, forces prg mode 3
            ldr_value  = '0;
            ldr_count  = '0;
            banks.ctrl = banks.ctrl | CTRL_RESET;
          end else begin
            if (ldr_count > LOADER_LAST) ldr_count = '0;
            ldr_value = ldr_value | (5'(acc.write_data[0]) << ldr_count);
            ldr_count = ldr_count + 3'd1;
            if (ldr_count == LOADER_BITS) begin
              case (reg_sel_e'(acc.address[14:13]))
                REG_CONTROL:  banks.ctrl     = ldr_value;
                REG_CHR_LOW:  banks.chr_low  = ldr_value;
                REG_CHR_HIGH: banks.chr_high = ldr_value;
                default:      banks.prg      = ldr_value;
              endcase
              ldr_value = '0;
              ldr_count = '0;
            end
          end
        end else begin
          res.target = TGT_PRG_ROM;
          res.offset = prg_window(acc.address[14]) + 18'(acc.address[13:0]);
        end
      end
    end else if (op == OP_PPU_RD) begin
      if (chr_ram_cfg) begin
        res.target = TGT_CHR_RAM;
        res.offset = 18'(acc.address[12:0]);
      end else begin
        res.target = TGT_CHR_ROM;
        res.offset = chr_window(acc.address[12]) + 18'(acc.address[11:0]);
      end
    end
    res.mirroring = banks.ctrl[1:0];
    return res;
  endfunction

  // driver: sends in bursts with random gaps, predicts on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left = 0;
      gap_left   = 0;
      ldr_value  = '0;
      ldr_count  = '0;
      banks      = '{ctrl: CTRL_RESET, chr_low: 5'd0, chr_high: 5'd0, prg: 5'd0};
    end else begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(translate_access(in_data_i));
      // a stalled payload holds; otherwise load the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_accesses.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // half the bursts run straight into the next one
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every accepted result against the oldest prediction, drives stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result with nothing expected: target %0d offset %h mirroring %0d",
                     $realtime, out_data_o.target, out_data_o.offset, out_data_o.mirroring);
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          if (out_data_o.target !== want.target || out_data_o.offset !== want.offset ||
              out_data_o.mirroring !== want.mirroring) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: mismatch: expected target %0d offset %h mirroring %0d, got %0d %h %0d",
                       $realtime, want.target, want.offset, want.mirroring,
                       out_data_o.target, out_data_o.offset, out_data_o.mirroring);
          end
        end
      end
      // stall pattern: free flow, light, heavy, long blocks
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ((mode_left % 16) < 12);
      endcase
    end
  end

  function automatic void queue_access(op_e op, logic [15:0] addr, logic [7:0] data);
    in_item_t acc;
    acc.opcode     = op;
    acc.address    = addr;
    acc.write_data = data;
    pending_accesses.push_back(acc);
  endfunction

  // any access that leaves the loader alone
  function automatic void queue_side_access();
    case ($urandom_range(0, 3))
      0:       queue_access(OP_CPU_RD, {1'b1, 15'($urandom)}, 8'($urandom));
      1:       queue_access(OP_PPU_RD, 16'($urandom), 8'($urandom));
      2:       queue_access(op_e'($urandom_range(0, 1)), {3'b011, 13'($urandom)}, 8'($urandom));
      default: queue_access(OP_CPU_WR, {1'b0, 15'($urandom_range(0, 16'h5FFF))}, 8'($urandom));
    endcase
  endfunction

  // serial writes of the low bits of value, lsb first, with optional unrelated accesses in between
  function automatic void queue_serial_load(reg_sel_e sel, logic [4:0] value, int bits,
                                            bit interleave);
    for (int i = 0; i < bits; i++) begin
      if (interleave && $urandom_range(0, 4) == 0) queue_side_access();
      queue_access(OP_CPU_WR, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), value[i]});
    end
  endfunction

  function automatic void build_random_traffic(int n);
    int stop_at;
    int r;
    stop_at = pending_accesses.size() + n;
    while (pending_accesses.size() < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_serial_load(reg_sel_e'($urandom_range(0, 3)), 5'($urandom), 5, 1'b1);
      end else if (r < 45) begin
        // partial load broken off by a loader clear
        queue_serial_load(reg_sel_e'($urandom_range(0, 3)), 5'($urandom),
                          $urandom_range(1, 4), 1'b1);
        queue_access(OP_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
      end else if (r < 70) begin
        queue_access(OP_CPU_RD, {1'b1, 15'($urandom)}, 8'($urandom));
      end else if (r < 88) begin
        queue_access(OP_PPU_RD, 16'($urandom), 8'($urandom));
      end else begin
        queue_access(op_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
    end
  endfunction

  task automatic write_cfg(logic idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PRG_BANK_COUNT) bank_count_cfg = value;
    else chr_ram_cfg = value[0];
  endtask

  // nothing queued, nothing in the input channel, nothing outstanding,
  // looked at once the edge has settled
  task automatic wait_idle();
    @(posedge clk_i);
    #1;
    while (pending_accesses.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (4) @(posedge clk_i);
  endtask

  logic [4:0] phase_count[8] = '{5'd16, 5'd1, 5'd16, 5'd0, 5'd31, 5'd8, 5'd0, 5'd0};
  logic       phase_ram[8]   = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state in prg mode 3 and 8k chr mode
    queue_access(OP_CPU_RD, 16'h8000, 8'h00);
    queue_access(OP_CPU_RD, 16'hFFFF, 8'hFF);
    queue_access(OP_PPU_RD, 16'h0000, 8'h00);
    queue_access(OP_PPU_RD, 16'hFFFF, 8'hFF);
    // work ram edges, accesses below work ram, the unused opcode
    queue_access(OP_CPU_RD, 16'h6000, 8'h00);
    queue_access(OP_CPU_WR, 16'h7FFF, 8'hFF);
    queue_access(OP_CPU_RD, 16'h5FFF, 8'h00);
    queue_access(OP_CPU_WR, 16'h0000, 8'hFF);
    queue_access(OP_NONE, 16'hFFFF, 8'hFF);
    // top prg bank, then every control bit set
    queue_serial_load(REG_PRG, 5'h1F, 5, 1'b0);
    queue_access(OP_CPU_RD, 16'h8000, 8'h00);
    queue_serial_load(REG_CONTROL, 5'h1F, 5, 1'b0);
    queue_access(OP_PPU_RD, 16'h1000, 8'h00);
    // half a load then a clear
    queue_serial_load(REG_CHR_HIGH, 5'h1F, 2, 1'b0);
    queue_access(OP_CPU_WR, 16'hFFFF, 8'h80);
    queue_access(OP_CPU_RD, 16'hC000, 8'h00);
    wait_idle();

    // phases over several configurations, the extremes first
    for (int p = 0; p < 8; p++) begin
      if (p < 6) begin
        write_cfg(CFG_PRG_BANK_COUNT, phase_count[p]);
        write_cfg(CFG_CHR_IS_RAM, phase_ram[p]);
      end else begin
        write_cfg(CFG_PRG_BANK_COUNT, 5'($urandom_range(1, 16)));
        write_cfg(CFG_CHR_IS_RAM, 1'($urandom));
      end
      build_random_traffic(175);
      wait_idle();
    end

    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
